>>> design/hht_pkg.sv
package hht_pkg;

   localparam int CycW  = 8;
   localparam int DotW  = 10;
   localparam int DotSW = DotW + 1;
   localparam int LineW = 8;
   localparam int CdW   = 11;
   localparam int IdxW  = 3;
   localparam int CfgW  = 8;
   localparam int RspW  = 32;

   localparam logic [DotSW-1:0] DotsPerLine  = DotSW'(456);
   localparam logic [DotW-1:0]  OamDots      = DotW'(80);
   localparam logic [DotW-1:0]  OamXferDots  = DotW'(80 + 172);
   localparam logic [LineW-1:0] VisibleLines = LineW'(144);
   localparam logic [LineW-1:0] LastLine     = LineW'(153);
   localparam logic [8:0]       DivLimit     = 9'd255;
   localparam logic [7:0]       CountMax     = 8'd255;

   localparam logic [IdxW-1:0] REG_TIMER_ENABLE = 3'd0;
   localparam logic [IdxW-1:0] REG_TIMER_RATE   = 3'd1;
   localparam logic [IdxW-1:0] REG_TIMER_MODULO = 3'd2;
   localparam logic [IdxW-1:0] REG_LCD_ENABLE   = 3'd3;
   localparam logic [IdxW-1:0] REG_LINE_COMPARE = 3'd4;
   localparam logic [IdxW-1:0] REG_STAT_IRQ_EN  = 3'd5;

   localparam logic [1:0] MODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_OAM    = 2'd2;
   localparam logic [1:0] MODE_XFER   = 2'd3;

   localparam logic [1:0] RATE_1024 = 2'd0;
   localparam logic [1:0] RATE_16   = 2'd1;
   localparam logic [1:0] RATE_64   = 2'd2;
   localparam logic [1:0] RATE_256  = 2'd3;

   localparam int IRQ_EN_HBLANK = 0;
   localparam int IRQ_EN_VBLANK = 1;
   localparam int IRQ_EN_OAM    = 2;
   localparam int IRQ_EN_COINC  = 3;

   typedef struct packed {
      logic             lcd_enable;
      logic [LineW-1:0] line_compare;
      logic [3:0]       irq_enables;
   } lcd_cfg_type;

   typedef struct packed {
      logic             vblank_irq;
      logic             lcd_irq;
      logic [1:0]       mode;
      logic             coincidence;
      logic [LineW-1:0] line;
      logic             draw;
   } lcd_result_type;

   function automatic logic [CdW-1:0] rate_reload(input logic [1:0] sel);
      logic [CdW-1:0] r;
      case (sel)
         RATE_1024: r = CdW'(1024);
         RATE_16:   r = CdW'(16);
         RATE_64:   r = CdW'(64);
         RATE_256:  r = CdW'(256);
         default:   r = CdW'(1024);
      endcase
      return r;
   endfunction

endpackage

>>> design/hht_lcd.sv
module hht_lcd (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [hht_pkg::CycW-1:0]       cycles,
   input  hht_pkg::lcd_cfg_type           cfg,
   output hht_pkg::lcd_result_type        result
);

   logic [hht_pkg::DotW-1:0]  dot_ff, dot_in;
   logic [hht_pkg::LineW-1:0] line_ff, line_in;
   logic [1:0]                mode_ff, mode_in;
   logic                      coinc_ff, coinc_in;
   logic                      want;
   logic                      lcd_irq;
   logic                      vblank_irq;
   logic                      draw;
   logic [hht_pkg::DotSW-1:0] pos;
   logic [hht_pkg::LineW-1:0] line_next;

   always_comb begin
      dot_in     = dot_ff;
      line_in    = line_ff;
      mode_in    = mode_ff;
      coinc_in   = coinc_ff;
      want       = 1'b0;
      lcd_irq    = 1'b0;
      vblank_irq = 1'b0;
      draw       = 1'b0;
      pos        = {1'b0, dot_ff} + hht_pkg::DotSW'(cycles);
      line_next  = line_ff + 8'd1;
      if (!cfg.lcd_enable) begin
         line_in = '0;
         mode_in = hht_pkg::MODE_VBLANK;
      end else begin
         if (line_ff >= hht_pkg::VisibleLines) begin
            mode_in = hht_pkg::MODE_VBLANK;
            want    = cfg.irq_enables[hht_pkg::IRQ_EN_VBLANK];
         end else if (dot_ff < hht_pkg::OamDots) begin
            mode_in = hht_pkg::MODE_OAM;
            want    = cfg.irq_enables[hht_pkg::IRQ_EN_OAM];
         end else if (dot_ff < hht_pkg::OamXferDots) begin
            mode_in = hht_pkg::MODE_XFER;
         end else begin
            mode_in = hht_pkg::MODE_HBLANK;
            want    = cfg.irq_enables[hht_pkg::IRQ_EN_HBLANK];
         end
         lcd_irq  = want && (mode_in != mode_ff);
         coinc_in = (line_ff == cfg.line_compare);
         if (coinc_in && cfg.irq_enables[hht_pkg::IRQ_EN_COINC]) begin
            lcd_irq = 1'b1;
         end
         if (pos >= hht_pkg::DotsPerLine) begin
            dot_in = '0;
            if (line_next == hht_pkg::VisibleLines) begin
               vblank_irq = 1'b1;
            end else if (line_next > hht_pkg::LastLine) begin
               line_next = '0;
            end
            draw    = line_next < hht_pkg::VisibleLines;
            line_in = line_next;
         end else begin
            dot_in = pos[hht_pkg::DotW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff   <= '0;
         line_ff  <= '0;
         mode_ff  <= hht_pkg::MODE_HBLANK;
         coinc_ff <= 1'b0;
      end else if (step) begin
         dot_ff   <= dot_in;
         line_ff  <= line_in;
         mode_ff  <= mode_in;
         coinc_ff <= coinc_in;
      end
   end

   assign result.vblank_irq  = vblank_irq;
   assign result.lcd_irq     = lcd_irq;
   assign result.mode        = mode_in;
   assign result.coincidence = coinc_in;
   assign result.line        = line_in;
   assign result.draw        = draw;

endmodule

>>> design/handheld_timer_and_lcd_timing.sv
// Channel | Ports                        | tdata / tuser contents
// req     | req_tvalid req_tready req_tdata | elapsed_cycles
// rsp     | rsp_tvalid rsp_tready rsp_tdata | see rsp_tdata port
// csr     | csr_we csr_index csr_wdata     | register writes, no read-back
//
// One beat per clock while rsp is not stalled: timer, divider and LCD state update in the accept cycle.
// The result beat appears in the output register in the cycle after its request is accepted.
// req_tready is high while the output register is empty or being drained.
// A stalled rsp holds its beat and blocks new requests until it is taken.
// Synchronous reset clears all timing state; lcd_enable comes up set.
module handheld_timer_and_lcd_timing (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [hht_pkg::CycW-1:0]    req_tdata,  // [7:0] elapsed_cycles
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [7:0] divider_value, [15:8] counter_value, [16] timer_irq,
   // [17] vblank_irq, [18] lcd_irq, [20:19] lcd_mode, [21] coincidence,
   // [29:22] current_line, [30] draw_line, [31] zero
   output logic [hht_pkg::RspW-1:0]    rsp_tdata,
   input  logic                        csr_we,
   input  logic [hht_pkg::IdxW-1:0]    csr_index,
   input  logic [hht_pkg::CfgW-1:0]    csr_wdata
);

   logic                       timer_en_ff;
   logic [1:0]                 rate_sel_ff;
   logic [7:0]                 modulo_ff;
   hht_pkg::lcd_cfg_type       lcd_cfg_ff;

   logic [7:0]                 div_acc_ff, div_acc_in;
   logic [7:0]                 div_ff, div_in;
   logic [hht_pkg::CdW-1:0]    cd_ff, cd_in;
   logic [7:0]                 count_ff, count_in;
   logic                       tirq;
   logic [8:0]                 div_sum;

   logic                       rsp_valid_ff;
   logic [hht_pkg::RspW-1:0]   rsp_data_ff;

   logic                       step;
   hht_pkg::lcd_result_type    lcd_res;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_en_ff            <= 1'b0;
         rate_sel_ff            <= hht_pkg::RATE_1024;
         modulo_ff              <= '0;
         lcd_cfg_ff.lcd_enable  <= 1'b1;
         lcd_cfg_ff.line_compare <= '0;
         lcd_cfg_ff.irq_enables <= '0;
      end else if (csr_we) begin
         case (csr_index)
            hht_pkg::REG_TIMER_ENABLE: timer_en_ff <= csr_wdata[0];
            hht_pkg::REG_TIMER_RATE:   rate_sel_ff <= csr_wdata[1:0];
            hht_pkg::REG_TIMER_MODULO: modulo_ff <= csr_wdata;
            hht_pkg::REG_LCD_ENABLE:   lcd_cfg_ff.lcd_enable <= csr_wdata[0];
            hht_pkg::REG_LINE_COMPARE: lcd_cfg_ff.line_compare <= csr_wdata;
            hht_pkg::REG_STAT_IRQ_EN:  lcd_cfg_ff.irq_enables <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      div_sum = {1'b0, div_acc_ff} + {1'b0, req_tdata};
      if (div_sum >= hht_pkg::DivLimit) begin
         div_acc_in = '0;
         div_in     = div_ff + 8'd1;
      end else begin
         div_acc_in = div_sum[7:0];
         div_in     = div_ff;
      end

      cd_in    = cd_ff;
      count_in = count_ff;
      tirq     = 1'b0;
      if (timer_en_ff) begin
         if (cd_ff <= hht_pkg::CdW'(req_tdata)) begin
            cd_in = hht_pkg::rate_reload(rate_sel_ff);
            if (count_ff == hht_pkg::CountMax) begin
               count_in = modulo_ff;
               tirq     = 1'b1;
            end else begin
               count_in = count_ff + 8'd1;
            end
         end else begin
            cd_in = cd_ff - hht_pkg::CdW'(req_tdata);
         end
      end
   end

   hht_lcd u_lcd (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cycles (req_tdata),
      .cfg    (lcd_cfg_ff),
      .result (lcd_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         div_acc_ff <= '0;
         div_ff     <= '0;
         cd_ff      <= '0;
         count_ff   <= '0;
      end else if (step) begin
         div_acc_ff <= div_acc_in;
         div_ff     <= div_in;
         cd_ff      <= cd_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= {1'b0, lcd_res.draw, lcd_res.line, lcd_res.coincidence,
                         lcd_res.mode, lcd_res.lcd_irq, lcd_res.vblank_irq, tirq,
                         count_in, div_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> design/hht_checker.sv
module hht_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [hht_pkg::RspW-1:0]    rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_line_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[29:22] <= hht_pkg::LastLine)
      else $error("line beyond last line");

   a_vblank_line: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17] |->
         rsp_tdata[29:22] == hht_pkg::VisibleLines && !rsp_tdata[30])
      else $error("vblank pulse off the first vblank line");

   a_draw_visible: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[30] |-> rsp_tdata[29:22] < hht_pkg::VisibleLines)
      else $error("draw request on a non-visible line");

endmodule

bind handheld_timer_and_lcd_timing hht_checker u_hht_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> test/handheld_timer_and_lcd_timing_tb.sv
module handheld_timer_and_lcd_timing_tb;

   localparam int OAM_END       = 80;
   localparam int XFER_END      = 80 + 172;
   localparam int LINE_DOTS     = 456;
   localparam int FIRST_VBLANK  = 144;
   localparam int LAST_LINE_NUM = 153;
   localparam int DIV_WRAP      = 255;
   localparam int N_PHASES      = 7;

   typedef struct packed {
      logic       reserved;
      logic       draw_line;
      logic [7:0] current_line;
      logic       coincidence;
      logic [1:0] lcd_mode;
      logic       lcd_irq;
      logic       vblank_irq;
      logic       timer_irq;
      logic [7:0] counter_value;
      logic [7:0] divider_value;
   } timing_beat_type;

   typedef enum logic [1:0] {ROW_CFG, ROW_BEAT} row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      logic [2:0]      index;
      logic [7:0]      value;      // register data or elapsed cycles
      logic            has_want;
      timing_beat_type want;
   } stim_row_type;

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [hht_pkg::CycW-1:0]  req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [hht_pkg::RspW-1:0]  rsp_tdata;
   logic                      csr_we     = 1'b0;
   logic [hht_pkg::IdxW-1:0]  csr_index  = '0;
   logic [hht_pkg::CfgW-1:0]  csr_wdata  = '0;

   // sideband carried with each request beat: a hand-typed expectation
   logic            beat_has_want = 1'b0;
   timing_beat_type beat_want     = '0;

   // register shadow
   logic       cfg_timer_en = 1'b0;
   logic [1:0] cfg_rate     = hht_pkg::RATE_1024;
   logic [7:0] cfg_modulo   = 8'd0;
   logic       cfg_lcd_en   = 1'b1;
   logic [7:0] cfg_compare  = 8'd0;
   logic [3:0] cfg_irq_en   = 4'd0;

   // timing state shadow
   int         div_accum  = 0;
   logic [7:0] div_byte   = 8'd0;
   int         countdown  = 0;
   logic [7:0] tick_count = 8'd0;
   int         dots       = 0;
   int         lines      = 0;
   logic [1:0] mode       = hht_pkg::MODE_HBLANK;
   logic       coinc      = 1'b0;

   timing_beat_type pending_beats[$];
   int              err_count = 0;
   bit              tx_steady = 1'b0;
   bit              rx_steady = 1'b0;
   int              rx_hold   = 0;

   stim_row_type dir_rows [0:31] = '{
      {ROW_BEAT, 3'd0, 8'd0,   1'b1,
       {1'b0, 1'b0, 8'd0, 1'b1, hht_pkg::MODE_OAM, 3'b000, 8'd0, 8'd0}},
      {ROW_BEAT, 3'd0, 8'd255, 1'b1,
       {1'b0, 1'b0, 8'd0, 1'b1, hht_pkg::MODE_OAM, 3'b000, 8'd0, 8'd1}},
      {ROW_BEAT, 3'd0, 8'd255, 1'b1,
       {1'b0, 1'b1, 8'd1, 1'b1, hht_pkg::MODE_HBLANK, 3'b000, 8'd0, 8'd2}},
      {ROW_CFG, hht_pkg::REG_STAT_IRQ_EN,  8'd15, 1'b0, 32'd0},
      {ROW_CFG, hht_pkg::REG_LINE_COMPARE, 8'd1, 1'b0, 32'd0},
      {ROW_CFG, hht_pkg::REG_TIMER_RATE,   {6'd0, hht_pkg::RATE_16}, 1'b0, 32'd0},
      {ROW_CFG, hht_pkg::REG_TIMER_MODULO, 8'd255, 1'b0, 32'd0},
      {ROW_CFG, hht_pkg::REG_TIMER_ENABLE, 8'd1, 1'b0, 32'd0},
      {ROW_BEAT, 3'd0, 8'd1,   1'b0, 32'd0},
      {ROW_BEAT, 3'd0, 8'd79,  1'b0, 32'd0},
      {ROW_BEAT, 3'd0, 8'd1,   1'b0, 32'd0},
      {ROW_BEAT, 3'd0, 8'd171, 1'b0, 32'd0},
      {ROW_BEAT, 3'd0, 8'd1,   1'b0, 32'd0},
      {ROW_BEAT, 3'd0, 8'd203, 1'b0, 32'd0},
      {ROW_CFG, hht_pkg::REG_LCD_ENABLE,   8'd0, 1'b0, 32'd0},
      {ROW_BEAT, 3'd0, 8'd128, 1'b0, 32'd0},
      {ROW_BEAT, 3'd0, 8'd255, 1'b0, 32'd0},
      {ROW_CFG, hht_pkg::REG_LCD_ENABLE,   8'd1, 1'b0, 32'd0},
      {ROW_CFG, hht_pkg::REG_LINE_COMPARE, 8'd0, 1'b0, 32'd0},
      {ROW_CFG, hht_pkg::REG_TIMER_RATE,   {6'd0, hht_pkg::RATE_1024}, 1'b0, 32'd0},
      {ROW_BEAT, 3'd0, 8'd0,   1'b0, 32'd0},
      {ROW_BEAT, 3'd0, 8'd255, 1'b0, 32'd0},
      {ROW_CFG, hht_pkg::REG_TIMER_RATE,   {6'd0, hht_pkg::RATE_64}, 1'b0, 32'd0},
      {ROW_BEAT, 3'd0, 8'd64,  1'b0, 32'd0},
      {ROW_BEAT, 3'd0, 8'd1,   1'b0, 32'd0},
      {ROW_CFG, hht_pkg::REG_TIMER_RATE,   {6'd0, hht_pkg::RATE_256}, 1'b0, 32'd0},
      {ROW_BEAT, 3'd0, 8'd200, 1'b0, 32'd0},
      {ROW_BEAT, 3'd0, 8'd255, 1'b0, 32'd0},
      {ROW_CFG, hht_pkg::REG_TIMER_ENABLE, 8'd0, 1'b0, 32'd0},
      {ROW_BEAT, 3'd0, 8'd3,   1'b0, 32'd0},
      {ROW_CFG, hht_pkg::REG_STAT_IRQ_EN,  8'd0, 1'b0, 32'd0},
      {ROW_BEAT, 3'd0, 8'd2,   1'b0, 32'd0}
   };

   handheld_timer_and_lcd_timing DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one instruction's worth of divider, timer and LCD timing
   function automatic timing_beat_type advance_timing(input logic [7:0] cyc);
      timing_beat_type b;
      logic [1:0]      mode_nxt;
      logic            want;
      int              pos;
      b = '0;
      div_accum = div_accum + cyc;
      if (div_accum >= DIV_WRAP) begin
         div_accum = 0;
         div_byte  = div_byte + 8'd1;
      end
      if (cfg_timer_en) begin
         countdown = countdown - int'(cyc);
         if (countdown <= 0) begin
            case (cfg_rate)
               hht_pkg::RATE_16:  countdown = 16;
               hht_pkg::RATE_64:  countdown = 64;
               hht_pkg::RATE_256: countdown = 256;
               default:           countdown = 1024;
            endcase
            if (tick_count == 8'd255) begin
               tick_count  = cfg_modulo;
               b.timer_irq = 1'b1;
            end else begin
               tick_count = tick_count + 8'd1;
            end
         end
      end
      if (!cfg_lcd_en) begin
         lines = 0;
         mode  = hht_pkg::MODE_VBLANK;
      end else begin
         want = 1'b0;
         if (lines >= FIRST_VBLANK) begin
            mode_nxt = hht_pkg::MODE_VBLANK;
            want     = cfg_irq_en[hht_pkg::IRQ_EN_VBLANK];
         end else if (dots < OAM_END) begin
            mode_nxt = hht_pkg::MODE_OAM;
            want     = cfg_irq_en[hht_pkg::IRQ_EN_OAM];
         end else if (dots < XFER_END) begin
            mode_nxt = hht_pkg::MODE_XFER;
         end else begin
            mode_nxt = hht_pkg::MODE_HBLANK;
            want     = cfg_irq_en[hht_pkg::IRQ_EN_HBLANK];
         end
         if (want && mode_nxt != mode) b.lcd_irq = 1'b1;
         mode = mode_nxt;
         if (lines == cfg_compare) begin
            coinc = 1'b1;
            if (cfg_irq_en[hht_pkg::IRQ_EN_COINC]) b.lcd_irq = 1'b1;
         end else begin
            coinc = 1'b0;
         end
         pos = dots + cyc;
         if (pos >= LINE_DOTS) begin
            pos   = 0;
            lines = lines + 1;
            if (lines == FIRST_VBLANK) b.vblank_irq = 1'b1;
            else if (lines > LAST_LINE_NUM) lines = 0;
            if (lines < FIRST_VBLANK) b.draw_line = 1'b1;
         end
         dots = pos;
      end
      b.divider_value = div_byte;
      b.counter_value = tick_count;
      b.lcd_mode      = mode;
      b.coincidence   = coinc;
      b.current_line  = 8'(lines);
      return b;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endtask

   always @(posedge clock) begin : scoreboard
      timing_beat_type got, want, calc;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_beats.size() == 0) begin
               $error("rsp beat with nothing expected: %h", rsp_tdata);
               err_count++;
            end else begin
               got  = rsp_tdata;
               want = pending_beats.pop_front();
               check_field("divider_value", want.divider_value, got.divider_value);
               check_field("counter_value", want.counter_value, got.counter_value);
               check_field("timer_irq",     want.timer_irq,     got.timer_irq);
               check_field("vblank_irq",    want.vblank_irq,    got.vblank_irq);
               check_field("lcd_irq",       want.lcd_irq,       got.lcd_irq);
               check_field("lcd_mode",      want.lcd_mode,      got.lcd_mode);
               check_field("coincidence",   want.coincidence,   got.coincidence);
               check_field("current_line",  want.current_line,  got.current_line);
               check_field("draw_line",     want.draw_line,     got.draw_line);
               check_field("reserved",      want.reserved,      got.reserved);
            end
         end
         if (req_tvalid && req_tready) begin
            calc = advance_timing(req_tdata);
            pending_beats.push_back(beat_has_want ? beat_want : calc);
         end
      end
   end

   always @(posedge clock) begin
      if (rx_hold > 0) begin
         rsp_tready <= 1'b0;
         rx_hold    <= rx_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!rx_steady && $urandom_range(0, 99) < 30) rx_hold <= idle_len();
      end
   end

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      csr_we     <= 1'b0;
      @(posedge clock);
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic cfg_write(input logic [hht_pkg::IdxW-1:0] idx,
                            input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         hht_pkg::REG_TIMER_ENABLE: cfg_timer_en = val[0];
         hht_pkg::REG_TIMER_RATE:   cfg_rate     = val[1:0];
         hht_pkg::REG_TIMER_MODULO: cfg_modulo   = val;
         hht_pkg::REG_LCD_ENABLE:   cfg_lcd_en   = val[0];
         hht_pkg::REG_LINE_COMPARE: cfg_compare  = val;
         hht_pkg::REG_STAT_IRQ_EN:  cfg_irq_en   = val[3:0];
         default: ;
      endcase
   endtask

   task automatic send_beat(input logic [7:0] cyc, input logic has_w,
                            input timing_beat_type w);
      int gap;
      gap = tx_steady ? 0 : idle_len();
      csr_we <= 1'b0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid    <= 1'b1;
      req_tdata     <= cyc;
      beat_has_want <= has_w;
      beat_want     <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin : stimulus
      logic       en, lcd;
      logic [1:0] rate;
      logic [7:0] modulo, compare, cyc;
      logic [3:0] irq_en;
      int         n, hold_at, r;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CFG) begin
            wait_idle();
            cfg_write(dir_rows[i].index, dir_rows[i].value);
         end else begin
            send_beat(dir_rows[i].value, dir_rows[i].has_want, dir_rows[i].want);
         end
      end

      for (int ph = 0; ph < N_PHASES; ph++) begin
         wait_idle();
         n = 170;
         case (ph)
            0: begin
               en = 1'b1; rate = hht_pkg::RATE_256; modulo = 8'd255;
               lcd = 1'b1; compare = 8'd255; irq_en = 4'hF;
            end
            1: begin
               en = 1'b0; rate = hht_pkg::RATE_1024; modulo = 8'd0;
               lcd = 1'b1; compare = 8'd0; irq_en = 4'h0;
            end
            2: begin
               // fast ticks so the counter wraps and reloads repeatedly
               en = 1'b1; rate = hht_pkg::RATE_16; modulo = 8'd250;
               lcd = 1'b1; compare = 8'd144; irq_en = 4'($urandom_range(0, 15));
            end
            5: begin
               en = 1'b1; rate = 2'($urandom_range(0, 3)); modulo = 8'd0;
               lcd = 1'b0; compare = 8'd0; irq_en = 4'hF;
               n = 25;
            end
            default: begin
               en      = ($urandom_range(0, 4) != 0);
               rate    = 2'($urandom_range(0, 3));
               modulo  = $urandom_range(0, 1) ? 8'($urandom_range(240, 255))
                                              : 8'($urandom_range(0, 255));
               lcd     = 1'b1;
               compare = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 153))
                                                    : 8'($urandom_range(0, 255));
               irq_en  = 4'($urandom_range(0, 15));
            end
         endcase
         cfg_write(hht_pkg::REG_TIMER_ENABLE, {7'd0, en});
         cfg_write(hht_pkg::REG_TIMER_RATE,   {6'd0, rate});
         cfg_write(hht_pkg::REG_TIMER_MODULO, modulo);
         cfg_write(hht_pkg::REG_LCD_ENABLE,   {7'd0, lcd});
         cfg_write(hht_pkg::REG_LINE_COMPARE, compare);
         cfg_write(hht_pkg::REG_STAT_IRQ_EN,  {4'd0, irq_en});
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         hold_at   = $urandom_range(5, n - 5);
         for (int k = 0; k < n; k++) begin
            if (k == hold_at) wait_idle();
            r = $urandom_range(0, 99);
            if (r < 55) cyc = 8'($urandom_range(160, 255));
            else if (r < 85) cyc = 8'($urandom_range(1, 24));
            else cyc = 8'($urandom_range(0, 255));
            send_beat(cyc, 1'b0, '0);
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/hht_pkg.sv
design/hht_lcd.sv
design/handheld_timer_and_lcd_timing.sv
design/hht_checker.sv
test/handheld_timer_and_lcd_timing_tb.sv
